// ===== hw/rtl/mplc_pkg.sv =====
package mplc_pkg;

    localparam int ID_W      = 8;
    localparam int MAP_W     = 64;
    localparam int ITEM_W    = 18;
    localparam int TOTAL_W   = 28;
    localparam int PREFIX_W  = 29;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 28'd268435455;

    // Item status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_PROTO_ERR = 2'd1;
    localparam logic [1:0] STATUS_DUP       = 2'd2;

    // Value kinds.
    localparam logic [2:0] VK_BYTE   = 3'd0;
    localparam logic [2:0] VK_INT16  = 3'd1;
    localparam logic [2:0] VK_INT32  = 3'd2;
    localparam logic [2:0] VK_VARINT = 3'd3;
    localparam logic [2:0] VK_BINARY = 3'd4;
    localparam logic [2:0] VK_STRING = 3'd5;
    localparam logic [2:0] VK_PAIR   = 3'd6;

    // Property identifiers.
    localparam logic [ID_W-1:0] PID_PAYLOAD_FORMAT     = 8'd1;
    localparam logic [ID_W-1:0] PID_MSG_EXPIRY         = 8'd2;
    localparam logic [ID_W-1:0] PID_CONTENT_TYPE       = 8'd3;
    localparam logic [ID_W-1:0] PID_RESPONSE_TOPIC     = 8'd8;
    localparam logic [ID_W-1:0] PID_CORRELATION_DATA   = 8'd9;
    localparam logic [ID_W-1:0] PID_SUB_ID             = 8'd11;
    localparam logic [ID_W-1:0] PID_SESSION_EXPIRY     = 8'd17;
    localparam logic [ID_W-1:0] PID_ASSIGNED_CLIENT_ID = 8'd18;
    localparam logic [ID_W-1:0] PID_SERVER_KEEP_ALIVE  = 8'd19;
    localparam logic [ID_W-1:0] PID_AUTH_METHOD        = 8'd21;
    localparam logic [ID_W-1:0] PID_AUTH_DATA          = 8'd22;
    localparam logic [ID_W-1:0] PID_REQ_PROBLEM_INFO   = 8'd23;
    localparam logic [ID_W-1:0] PID_WILL_DELAY         = 8'd24;
    localparam logic [ID_W-1:0] PID_REQ_RESPONSE_INFO  = 8'd25;
    localparam logic [ID_W-1:0] PID_RESPONSE_INFO      = 8'd26;
    localparam logic [ID_W-1:0] PID_SERVER_REF         = 8'd28;
    localparam logic [ID_W-1:0] PID_REASON_STRING      = 8'd31;
    localparam logic [ID_W-1:0] PID_RECEIVE_MAX        = 8'd33;
    localparam logic [ID_W-1:0] PID_TOPIC_ALIAS_MAX    = 8'd34;
    localparam logic [ID_W-1:0] PID_TOPIC_ALIAS        = 8'd35;
    localparam logic [ID_W-1:0] PID_MAX_QOS            = 8'd36;
    localparam logic [ID_W-1:0] PID_RETAIN_AVAIL       = 8'd37;
    localparam logic [ID_W-1:0] PID_USER_PROP          = 8'd38;
    localparam logic [ID_W-1:0] PID_MAX_PACKET_SIZE    = 8'd39;
    localparam logic [ID_W-1:0] PID_WILDCARD_AVAIL     = 8'd40;
    localparam logic [ID_W-1:0] PID_SUB_ID_AVAIL       = 8'd41;
    localparam logic [ID_W-1:0] PID_SHARED_SUB_AVAIL   = 8'd42;

    typedef struct packed {
        logic [2:0]  packet_kind;
        logic [7:0]  prop_id;
        logic [2:0]  value_kind;
        logic [31:0] num_value;
        logic [15:0] data_len;
        logic [15:0] pair_name_len;
        logic        topic_ok;
        logic        last_in_list;
    } req_t;

    typedef struct packed {
        logic [1:0]          item_status;
        logic [1:0]          list_status;
        logic [ITEM_W-1:0]   item_bytes;
        logic [TOTAL_W-1:0]  running_bytes;
        logic [PREFIX_W-1:0] bytes_with_prefix;
        logic                list_done;
    } rsp_t;

    typedef struct packed {
        logic [MAP_W-1:0]   seen_map;
        logic [TOTAL_W-1:0] byte_total;
        logic [1:0]         first_error;
    } list_state_t;

    // Packet kinds on which each identifier may appear, bit k for kind k.
    // Zero marks an unknown identifier.
    function automatic logic [7:0] allowed_kinds(input logic [ID_W-1:0] id);
        logic [7:0] mask;
        begin
            case (id)
                PID_PAYLOAD_FORMAT, PID_MSG_EXPIRY, PID_CONTENT_TYPE,
                PID_RESPONSE_TOPIC, PID_CORRELATION_DATA:              mask = 8'h84;
                PID_SUB_ID:                                            mask = 8'h0C;
                PID_SESSION_EXPIRY:                                    mask = 8'h23;
                PID_ASSIGNED_CLIENT_ID, PID_SERVER_KEEP_ALIVE:         mask = 8'h02;
                PID_AUTH_METHOD, PID_AUTH_DATA:                        mask = 8'h43;
                PID_REQ_PROBLEM_INFO:                                  mask = 8'h01;
                PID_WILL_DELAY:                                        mask = 8'h80;
                PID_REQ_RESPONSE_INFO:                                 mask = 8'h01;
                PID_RESPONSE_INFO:                                     mask = 8'h02;
                PID_SERVER_REF:                                        mask = 8'h22;
                PID_REASON_STRING:                                     mask = 8'hE2;
                PID_RECEIVE_MAX, PID_TOPIC_ALIAS_MAX:                  mask = 8'h03;
                PID_TOPIC_ALIAS:                                       mask = 8'h04;
                PID_MAX_QOS, PID_RETAIN_AVAIL:                         mask = 8'h02;
                PID_USER_PROP:                                         mask = 8'hFF;
                PID_MAX_PACKET_SIZE:                                   mask = 8'h03;
                PID_WILDCARD_AVAIL, PID_SUB_ID_AVAIL,
                PID_SHARED_SUB_AVAIL:                                  mask = 8'h02;
                default:                                               mask = 8'h00;
            endcase
            return mask;
        end
    endfunction

    // Byte count of a variable-length integer; five means it does not fit.
    function automatic logic [2:0] varint_size(input logic [31:0] v);
        logic [2:0] n;
        begin
            if (v < 32'd128) begin
                n = 3'd1;
            end else if (v < 32'd16384) begin
                n = 3'd2;
            end else if (v < 32'd2097152) begin
                n = 3'd3;
            end else if (v < 32'd268435456) begin
                n = 3'd4;
            end else begin
                n = 3'd5;
            end
            return n;
        end
    endfunction

endpackage

// ===== hw/rtl/mplc_prop_eval.sv =====
module mplc_prop_eval (
    input  mplc_pkg::req_t        req,
    input  mplc_pkg::list_state_t state,
    output mplc_pkg::rsp_t        rsp,
    output mplc_pkg::list_state_t state_next
);
    import mplc_pkg::*;

    logic [7:0]          mask;
    logic                known;
    logic                is_user_prop;
    logic                value_bad;
    logic                kind_bad;
    logic                dup;
    logic [1:0]          status;
    logic [1:0]          first_err;
    logic [MAP_W-1:0]    map_upd;
    logic [ITEM_W-1:0]   item;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  running;
    logic [2:0]          run_size;
    logic [PREFIX_W-1:0] prefixed;

    always_comb begin
        mask         = allowed_kinds(req.prop_id);
        known        = (mask != 8'h00);
        is_user_prop = (req.prop_id == PID_USER_PROP);
        kind_bad     = !mask[req.packet_kind];

        case (req.prop_id)
            PID_PAYLOAD_FORMAT, PID_REQ_PROBLEM_INFO, PID_REQ_RESPONSE_INFO,
            PID_MAX_QOS, PID_RETAIN_AVAIL, PID_WILDCARD_AVAIL,
            PID_SUB_ID_AVAIL, PID_SHARED_SUB_AVAIL: begin
                value_bad = (req.num_value[7:0] > 8'd1);
            end
            PID_MAX_PACKET_SIZE: begin
                value_bad = (req.num_value == 32'd0);
            end
            PID_RECEIVE_MAX, PID_TOPIC_ALIAS: begin
                value_bad = (req.num_value[15:0] == 16'd0);
            end
            PID_RESPONSE_TOPIC: begin
                value_bad = !req.topic_ok;
            end
            default: begin
                value_bad = 1'b0;
            end
        endcase

        // A known identifier always has an index below 64.
        dup = known && !is_user_prop && state.seen_map[req.prop_id[5:0]];

        if (value_bad || kind_bad) begin
            status = STATUS_PROTO_ERR;
        end else if (dup) begin
            status = STATUS_DUP;
        end else begin
            status = STATUS_OK;
        end

        map_upd = state.seen_map;
        if (known && !is_user_prop) begin
            map_upd[req.prop_id[5:0]] = 1'b1;
        end

        first_err = (state.first_error == STATUS_OK) ? status : state.first_error;

        case (req.value_kind)
            VK_BYTE:   item = 18'd2;
            VK_INT16:  item = 18'd3;
            VK_INT32:  item = 18'd5;
            VK_VARINT: begin
                if (req.num_value < 32'd268435456) begin
                    item = 18'd1 + {15'd0, varint_size(req.num_value)};
                end else begin
                    item = '0;
                end
            end
            VK_BINARY, VK_STRING: item = 18'd3 + {2'd0, req.data_len};
            VK_PAIR:   item = 18'd5 + {2'd0, req.data_len} + {2'd0, req.pair_name_len};
            default:   item = '0;
        endcase

        sum     = {1'b0, state.byte_total} + {{(TOTAL_W + 1 - ITEM_W){1'b0}}, item};
        running = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

        run_size = varint_size({{(32 - TOTAL_W){1'b0}}, running});
        if (req.last_in_list) begin
            prefixed = {1'b0, running} + {{(PREFIX_W - 3){1'b0}}, run_size};
        end else begin
            prefixed = '0;
        end

        rsp.item_status       = status;
        rsp.list_status       = first_err;
        rsp.item_bytes        = item;
        rsp.running_bytes     = running;
        rsp.bytes_with_prefix = prefixed;
        rsp.list_done         = req.last_in_list;

        // The whole list context starts over after the closing property.
        if (req.last_in_list) begin
            state_next = '0;
        end else begin
            state_next.seen_map    = map_upd;
            state_next.byte_total  = running;
            state_next.first_error = first_err;
        end
    end

endmodule

// ===== hw/rtl/mqtt5_property_list_checker_top.sv =====
// MQTT v5 property list checker.
// The input channel (s_valid, s_ready, s_data) carries one property request per
// transfer, tagged with the packet kind it belongs to; last_in_list closes a list.
// The result channel (m_valid, m_ready, m_data) returns exactly one result per
// request, in order: the item status, the sticky list status, the encoded size,
// the saturating running size and, on the closing property, the size including
// its length prefix.
// A request passes through an input register and a result register; the table
// lookup, the seen bitmap and the size sum for an item all complete
// combinationally between the two. One request is taken every cycle unless the
// receiver stalls with both registers full.
// Reset clears the valid flags of both pipeline registers and the list context
// (seen bitmap, running size, sticky status). When the receiver stalls, the result
// holds and one more request is buffered; s_ready drops only when both stages are
// full.
module mqtt5_property_list_checker_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mplc_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mplc_pkg::rsp_t m_data
);
    import mplc_pkg::*;

    logic        in_valid_reg;
    req_t        in_data_reg;
    logic        out_valid_reg;
    rsp_t        out_data_reg;
    list_state_t state_reg;
    list_state_t state_next;
    rsp_t        rsp;
    logic        out_free;
    logic        advance;

    mplc_prop_eval u_eval (
        .req        (in_data_reg),
        .state      (state_reg),
        .rsp        (rsp),
        .state_next (state_next)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
